// ===== hdl/cofc_pkg.sv =====
// ----------------------------------------------------------------------------
// cofc_pkg
// Shared codes, constants and types of the CANopen frame classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package cofc_pkg;

    // Message types
    localparam logic [2:0] MT_NONE    = 3'd0;
    localparam logic [2:0] MT_NMT     = 3'd1;
    localparam logic [2:0] MT_SYNC    = 3'd2;
    localparam logic [2:0] MT_TIME    = 3'd3;
    localparam logic [2:0] MT_EMCY    = 3'd4;
    localparam logic [2:0] MT_PDO     = 3'd5;
    localparam logic [2:0] MT_SDO     = 3'd6;
    localparam logic [2:0] MT_ERRCTL  = 3'd7;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_UNK_SDO = 2'd2;

    // Function codes
    localparam logic [3:0] FC_NMT        = 4'h0;
    localparam logic [3:0] FC_SYNC_EMCY  = 4'h1;
    localparam logic [3:0] FC_TIME       = 4'h2;
    localparam logic [3:0] FC_PDO_FIRST  = 4'h3;
    localparam logic [3:0] FC_PDO_LAST   = 4'hA;
    localparam logic [3:0] FC_SDO_SERVER = 4'hB;
    localparam logic [3:0] FC_SDO_CLIENT = 4'hC;
    localparam logic [3:0] FC_ERRCTL     = 4'hE;

    // SDO client command specifiers
    localparam logic [2:0] CCS_DN_SEG    = 3'd0;
    localparam logic [2:0] CCS_INIT_DN   = 3'd1;
    localparam logic [2:0] CCS_INIT_UP   = 3'd2;
    localparam logic [2:0] CCS_UP_SEG    = 3'd3;
    localparam logic [2:0] CCS_ABORT     = 3'd4;
    localparam logic [2:0] CCS_BLK_UP    = 3'd5;
    localparam logic [2:0] CCS_BLK_DN    = 3'd6;

    // SDO server command specifiers
    localparam logic [2:0] SCS_UP_SEG    = 3'd0;
    localparam logic [2:0] SCS_DN_SEG    = 3'd1;
    localparam logic [2:0] SCS_INIT_UP   = 3'd2;
    localparam logic [2:0] SCS_INIT_DN   = 3'd3;
    localparam logic [2:0] SCS_ABORT     = 3'd4;
    localparam logic [2:0] SCS_BLK_DN    = 3'd5;
    localparam logic [2:0] SCS_BLK_UP    = 3'd6;

    // Specifier with no layout on either side
    localparam logic [2:0] SDO_CS_RESERVED = 3'd7;

    // Frame geometry
    localparam int          MAX_BYTES  = 8;
    localparam logic [3:0]  LEN_MAX    = 4'd8;
    localparam logic [3:0]  NEED_NMT   = 4'd2;
    localparam logic [3:0]  NEED_TIME  = 4'd6;
    localparam logic [3:0]  NEED_FULL  = 4'd8;
    localparam logic [3:0]  EMCY_MSEF_BYTES = 4'd5;
    localparam logic [3:0]  SDO_SEG_BYTES   = 4'd7;
    localparam logic [3:0]  SDO_EXP_BYTES   = 4'd4;

    // TIME conversion
    localparam logic [16:0] TIME_DAY_OFFSET = 17'd5113;   // days 1970..1984
    localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
    localparam logic [9:0]  MS_PER_SEC      = 10'd1000;
    localparam logic [19:0] NS_PER_MS       = 20'd1000000;
    // floor(ms / 1000) == (ms * DIV1000_MAGIC) >> DIV1000_SHIFT for 32-bit ms
    localparam logic [28:0] DIV1000_MAGIC   = 29'd274877907;
    localparam int          DIV1000_SHIFT   = 38;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    function automatic logic [2:0] classify(input logic [3:0] fc, input logic [6:0] node);
        logic [2:0] mt;
        mt = MT_NONE;
        if (fc == FC_NMT) begin
            mt = MT_NMT;
        end else if (fc == FC_SYNC_EMCY) begin
            mt = (node == 7'd0) ? MT_SYNC : MT_EMCY;
        end else if (fc == FC_TIME) begin
            mt = MT_TIME;
        end else if (fc >= FC_PDO_FIRST && fc <= FC_PDO_LAST) begin
            mt = MT_PDO;
        end else if (fc == FC_SDO_SERVER || fc == FC_SDO_CLIENT) begin
            mt = MT_SDO;
        end else if (fc == FC_ERRCTL) begin
            mt = MT_ERRCTL;
        end
        return mt;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cofc_time_conv.sv =====
// ----------------------------------------------------------------------------
// cofc_time_conv
// Three-stage TIME frame conversion to Unix seconds and nanoseconds.
// ----------------------------------------------------------------------------
`default_nettype none

module cofc_time_conv (
    input  wire logic              i_clk,
    input  wire cofc_pkg::t_stage_en i_en,
    input  wire logic              i_is_time,
    input  wire logic [31:0]       i_ms,
    input  wire logic [15:0]       i_days,
    output logic [32:0]            o_secs,
    output logic [29:0]            o_nsecs
);

    localparam int PROD_W = 32 + 29;
    localparam int Q_W    = PROD_W - cofc_pkg::DIV1000_SHIFT;

    logic [PROD_W-1:0] n_prod;
    logic [31:0]       n_qk;
    logic [33:0]       n_dsec;
    logic [33:0]       n_sum;

    // stage 1
    logic              r1_is_time;
    logic [31:0]       r1_ms;
    logic [Q_W-1:0]    r1_q;
    logic [16:0]       r1_days;
    // stage 2
    logic              r2_is_time;
    logic [9:0]        r2_rem;
    logic [Q_W-1:0]    r2_q;
    logic [33:0]       r2_dsec;

    assign n_prod = PROD_W'(i_ms) * PROD_W'(cofc_pkg::DIV1000_MAGIC);
    assign n_qk   = 32'(r1_q) * 32'(cofc_pkg::MS_PER_SEC);
    assign n_dsec = 34'(r1_days) * 34'(cofc_pkg::SECS_PER_DAY);
    assign n_sum  = r2_dsec + 34'(r2_q);

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_is_time <= i_is_time;
            r1_ms      <= i_ms;
            r1_q       <= n_prod[PROD_W-1:cofc_pkg::DIV1000_SHIFT];
            r1_days    <= 17'(i_days) + cofc_pkg::TIME_DAY_OFFSET;
        end
        if (i_en.s2) begin
            r2_is_time <= r1_is_time;
            r2_rem     <= 10'(r1_ms - n_qk);
            r2_q       <= r1_q;
            r2_dsec    <= n_dsec;
        end
        if (i_en.s3) begin
            o_secs  <= r2_is_time ? n_sum[32:0] : 33'd0;
            o_nsecs <= r2_is_time ? 30'(30'(r2_rem) * 30'(cofc_pkg::NS_PER_MS)) : 30'd0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/canopen_frame_classifier_top.sv =====
// ----------------------------------------------------------------------------
// canopen_frame_classifier_top
// CANopen COB-ID classifier and NMT/SYNC/TIME/EMCY/PDO/SDO field decoder.
// ----------------------------------------------------------------------------
// One CAN frame goes in per transfer and one decoded result comes out per
// frame, in order. The block is a three-stage pipeline: length masking,
// classification and the divide-by-1000 reciprocal multiply in stage one,
// field extraction, remainder and day-seconds product in stage two, and the
// final sums and nanosecond product into the output register in stage
// three. A frame passes through the stage-one and stage-two registers
// into the output register that drives o_valid; a new frame is taken every
// cycle as long as the output side keeps up. A stalled output backs up the
// stages one by one, and o_ready drops only when all three hold a frame.
// Lengths above eight count as eight; bytes beyond the length read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module canopen_frame_classifier_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [10:0] i_cob_id,
    input  wire logic [3:0]  i_frame_len,
    input  wire logic [63:0] i_payload,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_msg_type,
    output logic [6:0]       o_node_addr,
    output logic [3:0]       o_func_code,
    output logic [2:0]       o_cmd_spec,
    output logic             o_has_index,
    output logic [15:0]      o_word_field,
    output logic [7:0]       o_byte_field,
    output logic [63:0]      o_data_field,
    output logic [3:0]       o_data_bytes,
    output logic [32:0]      o_time_secs,
    output logic [29:0]      o_time_nsecs,
    output logic [1:0]       o_status
);

    cofc_pkg::t_stage_en en;

    logic r_v1, r_v2, r_v3;

    // stage 0 combinational
    logic [3:0]  n_len;
    logic [63:0] n_p;
    logic [2:0]  n_mt;

    // stage 1 registers
    logic [63:0] r1_p;
    logic [3:0]  r1_len;
    logic [2:0]  r1_mt;
    logic [3:0]  r1_fc;
    logic [6:0]  r1_node;

    // stage 2 decode
    logic [2:0]  n_cs;
    logic        n_hasidx;
    logic [15:0] n_word;
    logic [7:0]  n_byte;
    logic [63:0] n_data;
    logic [3:0]  n_nbytes;
    logic [1:0]  n_status;
    logic [3:0]  n_need;
    logic        n_mux;
    logic [3:0]  n_dl;
    logic        n_known;

    // stage 2 registers
    logic [2:0]  r2_mt;
    logic [6:0]  r2_node;
    logic [3:0]  r2_fc;
    logic [2:0]  r2_cs;
    logic        r2_hasidx;
    logic [15:0] r2_word;
    logic [7:0]  r2_byte;
    logic [63:0] r2_data;
    logic [3:0]  r2_nbytes;
    logic [1:0]  r2_status;

    // stall chain: a stage loads when it is empty or its content moves on
    assign en.s3   = !r_v3 || i_ready;
    assign en.s2   = !r_v2 || en.s3;
    assign en.s1   = !r_v1 || en.s2;
    assign o_ready = en.s1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en.s1) begin
                r_v1 <= i_valid;
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // clamp length and zero the bytes past it
    always_comb begin
        n_len = (i_frame_len > cofc_pkg::LEN_MAX) ? cofc_pkg::LEN_MAX : i_frame_len;
        for (int i = 0; i < cofc_pkg::MAX_BYTES; i++) begin
            n_p[8*i +: 8] = (4'(i) < n_len) ? i_payload[8*i +: 8] : 8'h00;
        end
        n_mt = cofc_pkg::classify(i_cob_id[10:7], i_cob_id[6:0]);
    end

    always_ff @(posedge i_clk) begin
        if (en.s1) begin
            r1_p    <= n_p;
            r1_len  <= n_len;
            r1_mt   <= n_mt;
            r1_fc   <= i_cob_id[10:7];
            r1_node <= i_cob_id[6:0];
        end
    end

    cofc_time_conv u_time (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_is_time (n_mt == cofc_pkg::MT_TIME),
        .i_ms      (n_p[31:0]),
        .i_days    (n_p[47:32]),
        .o_secs    (o_time_secs),
        .o_nsecs   (o_time_nsecs)
    );

    // per-type field extraction
    always_comb begin
        n_cs     = 3'd0;
        n_hasidx = 1'b0;
        n_word   = 16'd0;
        n_byte   = 8'd0;
        n_data   = 64'd0;
        n_nbytes = 4'd0;
        n_status = cofc_pkg::ST_OK;
        n_need   = 4'd0;
        n_mux    = 1'b0;
        n_dl     = 4'd0;
        n_known  = 1'b1;
        unique case (r1_mt)
            cofc_pkg::MT_NMT: begin
                n_byte = r1_p[7:0];
                n_word = 16'(r1_p[15:8]);
                n_need = cofc_pkg::NEED_NMT;
            end
            cofc_pkg::MT_SYNC: begin
                n_byte = r1_p[7:0];
            end
            cofc_pkg::MT_TIME: begin
                n_need = cofc_pkg::NEED_TIME;
            end
            cofc_pkg::MT_EMCY: begin
                n_word   = r1_p[15:0];
                n_byte   = r1_p[23:16];
                n_data   = 64'(r1_p[63:24]);
                n_nbytes = cofc_pkg::EMCY_MSEF_BYTES;
                n_need   = cofc_pkg::NEED_FULL;
            end
            cofc_pkg::MT_PDO: begin
                n_data   = r1_p;
                n_nbytes = r1_len;
            end
            cofc_pkg::MT_SDO: begin
                n_cs = r1_p[7:5];
                if (r1_fc == cofc_pkg::FC_SDO_CLIENT) begin
                    unique case (n_cs) inside
                        cofc_pkg::CCS_DN_SEG: begin
                            n_dl = cofc_pkg::SDO_SEG_BYTES;
                        end
                        cofc_pkg::CCS_INIT_DN: begin
                            n_mux = 1'b1;
                            n_dl  = cofc_pkg::SDO_EXP_BYTES;
                        end
                        cofc_pkg::CCS_INIT_UP: begin
                            n_mux = 1'b1;
                        end
                        cofc_pkg::CCS_UP_SEG: begin
                        end
                        cofc_pkg::CCS_ABORT, cofc_pkg::CCS_BLK_UP,
                        cofc_pkg::CCS_BLK_DN: begin
                            n_mux = 1'b1;
                            n_dl  = cofc_pkg::SDO_EXP_BYTES;
                        end
                        default: begin
                            n_known = 1'b0;
                        end
                    endcase
                end else begin
                    unique case (n_cs) inside
                        cofc_pkg::SCS_UP_SEG: begin
                            n_dl = cofc_pkg::SDO_SEG_BYTES;
                        end
                        cofc_pkg::SCS_DN_SEG: begin
                        end
                        cofc_pkg::SCS_INIT_UP: begin
                            n_mux = 1'b1;
                            n_dl  = cofc_pkg::SDO_EXP_BYTES;
                        end
                        cofc_pkg::SCS_INIT_DN: begin
                            n_mux = 1'b1;
                        end
                        cofc_pkg::SCS_ABORT, cofc_pkg::SCS_BLK_DN,
                        cofc_pkg::SCS_BLK_UP: begin
                            n_mux = 1'b1;
                            n_dl  = cofc_pkg::SDO_EXP_BYTES;
                        end
                        default: begin
                            n_known = 1'b0;
                        end
                    endcase
                end
                if (!n_known) begin
                    n_status = cofc_pkg::ST_UNK_SDO;
                end else begin
                    n_need = cofc_pkg::NEED_FULL;
                    if (n_mux) begin
                        n_hasidx = 1'b1;
                        n_word   = r1_p[23:8];
                        n_byte   = r1_p[31:24];
                    end
                    // segment data follows the command byte, expedited
                    // data and abort codes follow the index
                    if (n_dl == cofc_pkg::SDO_SEG_BYTES) begin
                        n_data = 64'(r1_p[63:8]);
                    end else if (n_dl == cofc_pkg::SDO_EXP_BYTES) begin
                        n_data = 64'(r1_p[63:32]);
                    end
                    n_nbytes = n_dl;
                end
            end
            cofc_pkg::MT_ERRCTL: begin
                n_word = 16'(r1_p[7]);
                n_byte = {1'b0, r1_p[6:0]};
            end
            default: begin
            end
        endcase
        if (n_status == cofc_pkg::ST_OK && r1_len < n_need) begin
            n_status = cofc_pkg::ST_SHORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en.s2) begin
            r2_mt     <= r1_mt;
            r2_node   <= r1_node;
            r2_fc     <= r1_fc;
            r2_cs     <= n_cs;
            r2_hasidx <= n_hasidx;
            r2_word   <= n_word;
            r2_byte   <= n_byte;
            r2_data   <= n_data;
            r2_nbytes <= n_nbytes;
            r2_status <= n_status;
        end
        if (en.s3) begin
            o_msg_type   <= r2_mt;
            o_node_addr  <= r2_node;
            o_func_code  <= r2_fc;
            o_cmd_spec   <= r2_cs;
            o_has_index  <= r2_hasidx;
            o_word_field <= r2_word;
            o_byte_field <= r2_byte;
            o_data_field <= r2_data;
            o_data_bytes <= r2_nbytes;
            o_status     <= r2_status;
        end
    end

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !i_ready) |-> !o_ready)
        else $error("pipeline took a transfer while full and stalled");

    a_unk_sdo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == cofc_pkg::ST_UNK_SDO) |->
        (o_msg_type == cofc_pkg::MT_SDO && o_cmd_spec == cofc_pkg::SDO_CS_RESERVED &&
         !o_has_index))
        else $error("unknown specifier status on a non-SDO result");

    a_time_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_msg_type != cofc_pkg::MT_TIME) |->
        (o_time_secs == 33'd0 && o_time_nsecs == 30'd0))
        else $error("time fields set on a non-TIME result");

    a_nsecs_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_time_nsecs <= 30'd999000000))
        else $error("nanoseconds out of range");

    a_index_sdo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_index) |-> (o_msg_type == cofc_pkg::MT_SDO))
        else $error("index flag on a non-SDO result");

endmodule

`default_nettype wire
